@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the positional list store.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge outside reset.
`define PLC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Condition that must never be seen outside reset.
`define PLC_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define PLC_ASSERT(lbl, clk, rst_n, prop)
`define PLC_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/plc_pkg.sv @@
// ----------------------------------------------------------------------------
// plc_pkg
// Sizes, request codes and shared types of the positional list store.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam int CAPACITY     = 128;
    localparam int ELEMENT_BITS = 8;

    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int NLEAF    = 1 << IDX_W;
    localparam int TREE_LAT = IDX_W + 1;
    localparam int WAIT_W   = $clog2(TREE_LAT + 1);
    localparam int CMP_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_FIND   = 2'd3;

    typedef logic [ELEMENT_BITS-1:0] t_elem;
    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [CNT_W-1:0]        t_cnt;

    // Shift command broadcast to every cell.
    typedef struct packed {
        logic  ins;
        logic  del;
        t_idx  slot;
        t_elem value;
    } t_shift_ctrl;

    // Match command broadcast to every cell.
    typedef struct packed {
        logic  rd;
        logic  fnd;
        t_idx  slot;
        t_elem key;
        t_cnt  count;
    } t_search_ctrl;

    // One node of the reduction tree.
    typedef struct packed {
        logic  hit;
        t_idx  idx;
        t_elem data;
    } t_node;

endpackage

@@ rtl/plc_req_if.sv @@
// ----------------------------------------------------------------------------
// plc_req_if
// Request channel of the positional list store.
// ----------------------------------------------------------------------------
interface plc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] position;
    logic [7:0] value;

    modport source (output valid, output kind, output position, output value,
                    input ready);
    modport sink (input valid, input kind, input position, input value,
                  output ready);
endinterface

@@ rtl/plc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// plc_rsp_if
// Response channel of the positional list store.
// ----------------------------------------------------------------------------
interface plc_rsp_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [7:0] read_value;
    logic [7:0] found_position;
    logic [7:0] list_length;
    logic       is_empty;

    modport source (output valid, output ok, output read_value,
                    output found_position, output list_length, output is_empty,
                    input ready);
    modport sink (input valid, input ok, input read_value,
                  input found_position, input list_length, input is_empty,
                  output ready);
endinterface

@@ rtl/plc_cell.sv @@
// ----------------------------------------------------------------------------
// plc_cell
// One list slot: holds an element, shifts with its neighbours, flags a match.
// ----------------------------------------------------------------------------
module plc_cell
    import plc_pkg::*;
(
    input  logic         i_clk,
    input  t_idx         i_index,
    input  t_shift_ctrl  i_shift,
    input  t_search_ctrl i_search,
    input  t_elem        i_prev,
    input  t_elem        i_next,
    output t_elem        o_value,
    output logic         o_hit
);

    t_elem r_value;
    t_elem n_value;

    always_comb begin
        n_value = r_value;
        if (i_shift.ins) begin
            if (i_index == i_shift.slot) begin
                n_value = i_shift.value;
            end else if (i_index > i_shift.slot) begin
                n_value = i_prev;
            end
        end else if (i_shift.del && (i_index >= i_shift.slot)) begin
            n_value = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_hit   = (i_search.rd && (i_index == i_search.slot))
                  || (i_search.fnd && (r_value == i_search.key)
                      && (CNT_W'(i_index) < i_search.count));

endmodule

@@ rtl/plc_tree.sv @@
// ----------------------------------------------------------------------------
// plc_tree
// Registered binary tree that picks the lowest-indexed flagged cell.
// ----------------------------------------------------------------------------
module plc_tree
    import plc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_hit  [CAPACITY],
    input  t_elem i_data [CAPACITY],
    output t_node o_root
);

    // Heap order: node k has children 2k and 2k+1, leaves from NLEAF up.
    t_node r_heap [1:2*NLEAF-1];

    function automatic t_node pick(input t_node lo, input t_node hi);
        t_node res;
        res = hi;
        if (lo.hit) begin
            res = lo;
        end
        return res;
    endfunction

    for (genvar k = 0; k < NLEAF; k++) begin : g_leaf
        if (k < CAPACITY) begin : g_real
            always_ff @(posedge i_clk) begin
                r_heap[NLEAF+k] <= '{hit: i_hit[k], idx: t_idx'(k), data: i_data[k]};
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                r_heap[NLEAF+k] <= '{hit: 1'b0, idx: t_idx'(k), data: '0};
            end
        end
    end

    for (genvar k = 1; k < NLEAF; k++) begin : g_node
        always_ff @(posedge i_clk) begin
            r_heap[k] <= pick(r_heap[2*k], r_heap[2*k+1]);
        end
    end

    assign o_root = r_heap[1];

endmodule

@@ rtl/positional_list_store.sv @@
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of elements in a row of shifting cells, with insert, delete,
// read by position and find by value.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Transaction carries
//  --------+-----------+------------------------------------------------------
//  i_req   | in        | kind, position, value
//  o_rsp   | out       | ok, read_value, found_position, list_length, is_empty
//
// An insert or a delete shifts all the cells from its position onward at once, and its
// response is in the output register in the cycle after the transaction.
// A read or a find flags the matching cells and reduces the flags through a
// registered tree of IDX_W levels; its response is registered once the root
// has settled, after a wait set by the depth of that tree.
// One request is in flight at a time: i_req is ready only while no search is
// running and the output register is empty, so a stalled response holds the
// request channel.
// Reset empties the list at once; element contents need no clearing.
//
`include "assert_macros.svh"

module positional_list_store
    import plc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    plc_req_if.sink   i_req,
    plc_rsp_if.source o_rsp
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SEARCH = 1'b1;

    logic         r_state;
    logic         n_state;
    t_cnt         r_count;
    t_cnt         n_count;
    logic [WAIT_W-1:0] r_wait;
    t_search_ctrl r_search;
    logic         r_is_read;

    logic         r_out_valid;
    logic         r_ok;
    logic [7:0]   r_read_value;
    logic [7:0]   r_found;
    logic [7:0]   r_length;
    logic         r_empty;

    logic         w_accept;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_cnt;
    logic         w_ins_ok;
    logic         w_pos_ok;
    t_idx         w_slot;
    t_shift_ctrl  w_shift;
    logic         w_done;

    t_elem        w_value [CAPACITY];
    logic         w_hit   [CAPACITY];
    t_node        w_root;

    // The request channel opens only when nothing is pending downstream.
    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;
    assign w_accept    = i_req.valid && i_req.ready;

    // Range checks are done on widened copies so that neither side wraps.
    assign w_pos    = CMP_W'(i_req.position);
    assign w_cnt    = CMP_W'(r_count);
    assign w_pos_ok = (i_req.position != 8'd0) && (w_pos <= w_cnt);
    assign w_ins_ok = (i_req.position != 8'd0) && (w_pos <= w_cnt + CMP_W'(1))
                   && (w_cnt < CMP_W'(CAPACITY));
    assign w_slot   = t_idx'(w_pos - CMP_W'(1));

    always_comb begin
        w_shift.ins   = w_accept && (i_req.kind == KIND_INSERT) && w_ins_ok;
        w_shift.del   = w_accept && (i_req.kind == KIND_DELETE) && w_pos_ok;
        w_shift.slot  = w_slot;
        w_shift.value = ELEMENT_BITS'(i_req.value);
    end

    always_comb begin
        n_count = r_count;
        if (w_shift.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_shift.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // The row of cells: each takes its left neighbour on an insert and its
    // right neighbour on a delete. The ends are tied to their own value.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        plc_cell u_cell (
            .i_clk    (i_clk),
            .i_index  (t_idx'(k)),
            .i_shift  (w_shift),
            .i_search (r_search),
            .i_prev   (w_value[(k == 0) ? 0 : k - 1]),
            .i_next   (w_value[(k == CAPACITY - 1) ? k : k + 1]),
            .o_value  (w_value[k]),
            .o_hit    (w_hit[k])
        );
    end

    plc_tree u_tree (
        .i_clk  (i_clk),
        .i_hit  (w_hit),
        .i_data (w_value),
        .o_root (w_root)
    );

    // The search command is held steady, so the tree root settles once the
    // flags have passed every level.
    assign w_done = (r_state == S_SEARCH) && (r_wait == WAIT_W'(TREE_LAT));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && ((i_req.kind == KIND_READ) || (i_req.kind == KIND_FIND))) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_wait       <= '0;
            r_search.rd  <= 1'b0;
            r_search.fnd <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;

            if (r_state == S_SEARCH) begin
                r_wait <= r_wait + WAIT_W'(1);
            end else begin
                r_wait <= '0;
            end

            if (w_accept) begin
                r_search.rd    <= (i_req.kind == KIND_READ) && w_pos_ok;
                r_search.fnd   <= (i_req.kind == KIND_FIND);
                r_search.slot  <= w_slot;
                r_search.key   <= ELEMENT_BITS'(i_req.value);
                r_search.count <= r_count;
            end

            if (w_accept && ((i_req.kind == KIND_INSERT) || (i_req.kind == KIND_DELETE))) begin
                r_out_valid <= 1'b1;
            end else if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_read <= (i_req.kind == KIND_READ);
        end

        if (w_accept) begin
            r_ok         <= w_shift.ins || w_shift.del;
            r_read_value <= 8'd0;
            r_found      <= 8'd0;
            r_length     <= 8'(n_count);
            r_empty      <= (n_count == '0);
        end else if (w_done) begin
            r_ok         <= w_root.hit;
            r_read_value <= (r_is_read && w_root.hit) ? 8'(w_root.data) : 8'd0;
            r_found      <= (!r_is_read && w_root.hit)
                            ? 8'(CNT_W'(w_root.idx) + CNT_W'(1)) : 8'd0;
            r_length     <= 8'(r_count);
            r_empty      <= (r_count == '0);
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.ok             = r_ok;
    assign o_rsp.read_value     = r_read_value;
    assign o_rsp.found_position = r_found;
    assign o_rsp.list_length    = r_length;
    assign o_rsp.is_empty       = r_empty;

    // A running search and a waiting response never overlap.
    `PLC_NEVER(a_search_excl, i_clk, i_rst_n, r_out_valid && (r_state == S_SEARCH))
    // The list never grows past its capacity.
    `PLC_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    // An accepted insert lengthens the list by exactly one.
    `PLC_ASSERT(a_ins_count, i_clk, i_rst_n,
                w_shift.ins |=> r_count == $past(r_count) + CNT_W'(1))
    // The length is frozen while a search is running.
    `PLC_ASSERT(a_search_len, i_clk, i_rst_n, (r_state == S_SEARCH) |=> $stable(r_count))

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list store. Each accepted request
// is run through a behavioural copy of the list, and the reply it predicts
// is compared with the reply the block returns.
// ----------------------------------------------------------------------------
module tb_top
    import plc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // A read or a find comes back after a wait set by the tree depth;
    // the closing pause is sized from it.
    localparam int SEARCH_LATENCY = IDX_W + 2;
    localparam int STALL_LIMIT    = 4000;
    localparam int MAX_REPORTS    = 10;

    // One reply as the block presents it on the response channel.
    typedef struct packed {
        logic       ok;
        logic [7:0] read_value;
        logic [7:0] found_position;
        logic [7:0] list_length;
        logic       is_empty;
    } t_list_reply;

    logic clk = 1'b0;
    logic rst_n;

    plc_req_if req_if ();
    plc_rsp_if rsp_if ();

    positional_list_store u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #2 clk = ~clk;

    // Behavioural copy of the list: the elements in order and their number.
    t_elem model_elems [CAPACITY];
    int    model_count = 0;

    // Replies predicted for accepted requests, oldest first.
    t_list_reply pending_replies [$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_cycles   = 0;

    // Applies one request to the behavioural list and returns the reply the
    // block should give for it. Positions are 1-based throughout.
    function automatic t_list_reply predict_list_reply(logic [1:0] kind,
                                                       logic [7:0] pos,
                                                       logic [7:0] val);
        t_list_reply r;
        int          p;
        int          j;
        r = '0;
        p = int'(pos);
        case (kind)
            KIND_INSERT: begin
                if (p >= 1 && p <= model_count + 1 && model_count < CAPACITY) begin
                    for (j = model_count; j > p - 1; j--)
                        model_elems[j] = model_elems[j-1];
                    model_elems[p-1] = val;
                    model_count++;
                    r.ok = 1'b1;
                end
            end
            KIND_DELETE: begin
                if (p >= 1 && p <= model_count) begin
                    for (j = p - 1; j + 1 < model_count; j++)
                        model_elems[j] = model_elems[j+1];
                    model_count--;
                    r.ok = 1'b1;
                end
            end
            KIND_READ: begin
                if (p >= 1 && p <= model_count) begin
                    r.read_value = model_elems[p-1];
                    r.ok         = 1'b1;
                end
            end
            default: begin
                // The first match wins, so the scan stops once one is seen.
                for (j = 0; j < model_count && !r.ok; j++) begin
                    if (model_elems[j] == val) begin
                        r.found_position = 8'(j + 1);
                        r.ok             = 1'b1;
                    end
                end
            end
        endcase
        r.list_length = 8'(model_count);
        r.is_empty    = (model_count == 0);
        return r;
    endfunction

    // A position the current list accepts for the given kind of request, or 1 for any other kind on an empty list.
    function automatic logic [7:0] legal_position(logic [1:0] kind);
        if (kind == KIND_INSERT)
            return 8'($urandom_range(model_count + 1, 1));
        if (model_count == 0)
            return 8'd1;
        return 8'($urandom_range(model_count, 1));
    endfunction

    // Values are drawn so that finds hit often and duplicates are common:
    // sometimes an element already held, sometimes a value from a tiny set.
    function automatic logic [7:0] pick_value();
        if ($urandom_range(3) == 0 && model_count > 0)
            return model_elems[$urandom_range(model_count - 1)];
        if ($urandom_range(1) == 0)
            return 8'($urandom_range(3));
        return 8'($urandom_range(255));
    endfunction

    // Offers one request and holds it until the block takes it. Valid stays
    // high between back-to-back transactions unless an idle cycle is drawn.
    task automatic send_request(logic [1:0] kind, logic [7:0] pos, logic [7:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.kind     <= kind;
        req_if.position <= pos;
        req_if.value    <= val;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pending_replies.push_back(predict_list_reply(kind, pos, val));
    endtask

    // Every request on an empty list except a well-placed insert must be
    // turned away, and so must an insert beyond the end.
    task automatic test_empty_list();
        send_request(KIND_READ,   8'd1, 8'h00);
        send_request(KIND_DELETE, 8'd1, 8'hFF);
        send_request(KIND_FIND,   8'd0, 8'h00);
        send_request(KIND_INSERT, 8'd0, 8'h05);
        send_request(KIND_INSERT, 8'd2, 8'h05);
    endtask

    // Builds a short list with inserts at the front, the end and the middle,
    // then probes both ends of every range and searches with duplicates.
    task automatic test_positions_and_search();
        send_request(KIND_INSERT, 8'd1,   8'hFF);
        send_request(KIND_INSERT, 8'd1,   8'h00);
        send_request(KIND_INSERT, 8'd3,   8'h80);
        send_request(KIND_INSERT, 8'd2,   8'h00);
        send_request(KIND_INSERT, 8'd5,   8'h01);
        send_request(KIND_READ,   8'd0,   8'hFF);
        send_request(KIND_READ,   8'd5,   8'h00);
        send_request(KIND_READ,   8'd6,   8'h00);
        send_request(KIND_READ,   8'd255, 8'h00);
        send_request(KIND_READ,   8'd1,   8'h00);
        send_request(KIND_FIND,   8'd0,   8'h00);
        send_request(KIND_FIND,   8'd255, 8'hFF);
        send_request(KIND_FIND,   8'd0,   8'h01);
        send_request(KIND_FIND,   8'd0,   8'h77);
        send_request(KIND_DELETE, 8'd0,   8'h00);
        send_request(KIND_DELETE, 8'd6,   8'h00);
        send_request(KIND_DELETE, 8'd255, 8'h00);
        send_request(KIND_DELETE, 8'd5,   8'h00);
        send_request(KIND_DELETE, 8'd1,   8'h00);
        send_request(KIND_INSERT, 8'd255, 8'hAA);
    endtask

    // Random mix of all four requests. Most positions are legal for the
    // current length; one in ten is drawn from the full field as noise.
    task automatic test_random_mix(int n_items);
        int         i;
        int         roll;
        logic [1:0] kind;
        logic [7:0] pos;
        for (i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            if (roll < 35)
                kind = KIND_INSERT;
            else if (roll < 60)
                kind = KIND_DELETE;
            else if (roll < 80)
                kind = KIND_READ;
            else
                kind = KIND_FIND;
            if ($urandom_range(9) == 0)
                pos = 8'($urandom_range(255));
            else
                pos = legal_position(kind);
            send_request(kind, pos, pick_value());
        end
    endtask

    // Fills the list to capacity, checks that further inserts bounce off
    // the full store, searches the full list and then empties it again.
    task automatic test_fill_and_drain();
        int i;
        while (model_count < CAPACITY)
            send_request(KIND_INSERT, legal_position(KIND_INSERT), pick_value());
        send_request(KIND_INSERT, 8'(CAPACITY + 1), pick_value());
        for (i = 0; i < 3; i++)
            send_request(KIND_INSERT, 8'($urandom_range(CAPACITY + 1, 1)), pick_value());
        send_request(KIND_READ, 8'(CAPACITY), 8'h00);
        send_request(KIND_READ, 8'(CAPACITY + 1), 8'h00);
        for (i = 0; i < 10; i++) begin
            if ($urandom_range(1) == 0)
                send_request(KIND_READ, legal_position(KIND_READ), pick_value());
            else
                send_request(KIND_FIND, 8'($urandom_range(255)), pick_value());
        end
        while (model_count > 0)
            send_request(KIND_DELETE, legal_position(KIND_DELETE), pick_value());
        send_request(KIND_DELETE, 8'd1, 8'h00);
    endtask

    // Response side: ready is redrawn every cycle, and each transaction
    // seen at an edge is checked against the oldest prediction.
    always @(posedge clk) begin
        t_list_reply got;
        t_list_reply want;
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.ok, rsp_if.read_value, rsp_if.found_position,
                    rsp_if.list_length, rsp_if.is_empty};
            if (pending_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] reply with no request outstanding: ", $realtime,
                             "ok=%b rd=%0d fp=%0d len=%0d e=%b",
                             got.ok, got.read_value, got.found_position,
                             got.list_length, got.is_empty);
            end else begin
                want = pending_replies.pop_front();
                if (got.ok !== want.ok || got.read_value !== want.read_value ||
                    got.found_position !== want.found_position ||
                    got.list_length !== want.list_length ||
                    got.is_empty !== want.is_empty) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] reply mismatch: ", $realtime,
                                 "expected ok=%b rd=%0d fp=%0d len=%0d e=%b, ",
                                 want.ok, want.read_value, want.found_position,
                                 want.list_length, want.is_empty,
                                 "got ok=%b rd=%0d fp=%0d len=%0d e=%b",
                                 got.ok, got.read_value, got.found_position,
                                 got.list_length, got.is_empty);
                end
            end
        end
    end

    // Watchdog: a long run of cycles without any transaction on either
    // channel means the block has hung.
    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("hang: no transaction for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        rst_n           <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.kind     <= KIND_INSERT;
        req_if.position <= 8'd0;
        req_if.value    <= 8'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender mostly busy, receiver mostly stalling.
        send_idle_pct = 9;
        recv_idle_pct = 86;
        test_empty_list();
        test_positions_and_search();
        test_random_mix(60);

        // Roles swapped: sparse requests, an eager receiver.
        send_idle_pct = 86;
        recv_idle_pct = 9;
        test_fill_and_drain();

        // Back-to-back traffic with no gaps on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(70);

        req_if.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SEARCH_LATENCY + 4) @(posedge clk);

        if (pending_replies.size() != 0) begin
            mismatch_count++;
            $display("%0d replies never arrived", pending_replies.size());
        end
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/plc_pkg.sv
rtl/plc_req_if.sv
rtl/plc_rsp_if.sv
rtl/plc_cell.sv
rtl/plc_tree.sv
rtl/positional_list_store.sv
dv/tb_top.sv
